// ----- sv/cell_instance_point_transform_defines.svh -----
// Assertion macros for the cell instance point transform.
// Used by the top level; expects clk and rst in scope.
`ifndef CELL_INSTANCE_POINT_TRANSFORM_DEFINES_SVH
`define CELL_INSTANCE_POINT_TRANSFORM_DEFINES_SVH

// antecedent implies consequent, checked out of reset
`define CIPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cipt: implication check failed");

// condition must never hold out of reset
`define CIPT_ASSERT_NEVER(lbl, cond) \
  `CIPT_ASSERT_IMP(lbl, 1'b1, !(cond))

`endif

// ----- sv/cipt_pkg.sv -----
// Shared constants for the cell instance point transform.
// No dependencies; used by cipt_scale and the top level.
`default_nettype none

package cipt_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MAGNIFICATION = 3'd0;
  localparam logic [2:0] REG_NEGATE_X      = 3'd1;
  localparam logic [2:0] REG_NEGATE_Y      = 3'd2;
  localparam logic [2:0] REG_ROTATE_ENABLE = 3'd3;
  localparam logic [2:0] REG_COS           = 3'd4;
  localparam logic [2:0] REG_SIN           = 3'd5;
  localparam logic [2:0] REG_OFFSET_X      = 3'd6;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd7;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int OUT_BITS       = 48;

  // magnification in thousandths; a value of one means no scaling
  localparam int MAG_BITS   = 16;
  localparam int MAG_UNITY  = 1;
  localparam int SCALE_DIV  = 1000;

  // divide by 1000 = shift by 3, then divide by 125
  localparam int DIV_SHIFT    = 3;
  localparam int DIV_ODD      = 125;
  localparam int DIV_ODD_BITS = 7;

  // low chunk of the dividend, remainder bits and low-chunk reciprocal
  localparam int LO_BITS  = 24;
  localparam int REM_BITS = 7;
  localparam int NL_BITS  = REM_BITS + LO_BITS;
  localparam int KL       = NL_BITS + DIV_ODD_BITS;
  localparam logic [31:0] ML = 32'd2199023255;  // floor(2^38 / 125)

  // scaled coordinate grows by this many bits (sign and 65.535x)
  localparam int SCALE_GROWTH = 7;
  localparam int SCALE_LAT    = 7;
  localparam int ROT_LAT      = 5;

endpackage

`default_nettype wire

// ----- sv/cipt_scale.sv -----
// One coordinate: scale by magnification / 1000 (truncate toward zero)
// and optional negation, as a seven-stage pipeline. Depends on cipt_pkg.
`default_nettype none

module cipt_scale import cipt_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                                        clk,
  input  logic signed [COORD_BITS-1:0]                coord,
  input  logic        [MAG_BITS-1:0]                  mag_eff,
  input  logic                                        negate,
  output logic signed [COORD_BITS+SCALE_GROWTH-1:0]   scaled
);

  localparam int XW  = COORD_BITS + SCALE_GROWTH;
  localparam int PW  = COORD_BITS + MAG_BITS;
  localparam int QW  = PW - DIV_SHIFT;
  localparam int QHW = QW - LO_BITS;
  localparam int KH  = QHW + DIV_ODD_BITS;
  localparam int MHW = QHW + 1;
  localparam int HPW = QHW + MHW;
  localparam int WR  = QHW + REM_BITS;
  localparam logic [MHW-1:0] MH = MHW'((64'd1 << KH) / DIV_ODD);

  // stage A: magnitude and final sign
  logic [COORD_BITS-1:0] mag_a;
  logic                  flip_a;
  // stage B: magnitude times magnification
  logic [PW-1:0]         prod_b;
  logic                  flip_b;
  // stage C: high-chunk quotient estimate
  logic [QHW-1:0]        qh_in_c;
  logic [QHW-1:0]        qh_est_c;
  logic [LO_BITS-1:0]    ql_c;
  logic                  flip_c;
  // stage D: corrected high quotient and remainder
  logic [QHW-1:0]        qh_d;
  logic [REM_BITS-1:0]   rh_d;
  logic [LO_BITS-1:0]    ql_d;
  logic                  flip_d;
  // stage E: low-chunk quotient estimate
  logic [NL_BITS-1:0]    n_e;
  logic [LO_BITS-1:0]    ql_est_e;
  logic [QHW-1:0]        qh_e;
  logic                  flip_e;
  // stage F: full quotient
  logic [QW-1:0]         q_f;
  logic                  flip_f;

  logic [HPW-1:0]        hprod;
  logic [WR-1:0]         rem_h;
  logic [QHW-1:0]        qh_fix;
  logic [REM_BITS-1:0]   rh_fix;
  logic [NL_BITS-1:0]    n_d;
  logic [63:0]           lprod;
  logic [NL_BITS-1:0]    rem_l;
  logic [LO_BITS-1:0]    ql_fix;
  logic signed [XW-1:0]  q_s;

  // high chunk: reciprocal multiply, low by at most one
  assign hprod = HPW'(prod_b[PW-1:PW-QHW]) * HPW'(MH);

  // high chunk correction
  always_comb begin
    rem_h = WR'(qh_in_c) - WR'(qh_est_c) * WR'(DIV_ODD);
    if (rem_h >= WR'(DIV_ODD)) begin
      qh_fix = qh_est_c + 1'b1;
      rh_fix = REM_BITS'(rem_h - WR'(DIV_ODD));
    end else begin
      qh_fix = qh_est_c;
      rh_fix = REM_BITS'(rem_h);
    end
  end

  // low chunk: remainder of the high chunk joined with the low bits
  assign n_d   = {rh_d, ql_d};
  assign lprod = 64'(n_d) * 64'(ML);

  // low chunk correction
  always_comb begin
    rem_l = n_e - NL_BITS'(ql_est_e) * NL_BITS'(DIV_ODD);
    if (rem_l >= NL_BITS'(DIV_ODD)) begin
      ql_fix = ql_est_e + 1'b1;
    end else begin
      ql_fix = ql_est_e;
    end
  end

  assign q_s = $signed(XW'(q_f));

  // datapath registers
  always_ff @(posedge clk) begin
    mag_a    <= coord[COORD_BITS-1] ? COORD_BITS'(-coord) : COORD_BITS'(coord);
    flip_a   <= coord[COORD_BITS-1] ^ negate;

    prod_b   <= PW'(mag_a) * PW'(mag_eff);
    flip_b   <= flip_a;

    qh_in_c  <= prod_b[PW-1:PW-QHW];
    qh_est_c <= QHW'(hprod >> KH);
    ql_c     <= prod_b[DIV_SHIFT+LO_BITS-1:DIV_SHIFT];
    flip_c   <= flip_b;

    qh_d     <= qh_fix;
    rh_d     <= rh_fix;
    ql_d     <= ql_c;
    flip_d   <= flip_c;

    n_e      <= n_d;
    ql_est_e <= LO_BITS'(lprod >> KL);
    qh_e     <= qh_d;
    flip_e   <= flip_d;

    q_f      <= {qh_e, ql_fix};
    flip_f   <= flip_e;

    scaled   <= flip_f ? -q_s : q_s;
  end

endmodule

`default_nettype wire

// ----- sv/cell_instance_point_transform.sv -----
// One item per cycle, every cycle, so busy stays low. Depth is set by the
// scaling divider (7 stages) and the rotation multiply, combine, sum,
// truncate and offset stages (5). rst is synchronous: it empties the
// pipeline and restores every configuration register to its reset value.
`default_nettype none
`include "cell_instance_point_transform_defines.svh"

module cell_instance_point_transform import cipt_pkg::*; #(
  parameter int COORD_BITS     = 32,
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  output logic                          done,
  output logic signed [OUT_BITS-1:0]    placed_x,
  output logic signed [OUT_BITS-1:0]    placed_y,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int XW       = COORD_BITS + SCALE_GROWTH;
  localparam int T        = TRIG_FRAC_BITS + 2;
  localparam int XL       = (XW + 1) / 2;
  localparam int XH       = XW - XL;
  localparam int PLW      = XL + T + 1;
  localparam int PHW      = XH + T;
  localparam int PFW      = XW + T;
  localparam int RW       = PFW + 1;
  localparam int TW       = RW - TRIG_FRAC_BITS;
  localparam int SW       = COORD_BITS + 11;
  localparam int OFF_W    = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int PIPE_LAT = SCALE_LAT + ROT_LAT;
  localparam logic signed [RW-1:0] TBIAS = RW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
  localparam logic [T-1:0] TRIG_ONE = T'(64'd1 << TRIG_FRAC_BITS);

  // configuration registers (magnification held as the effective multiplier)
  logic [MAG_BITS-1:0]      mag_eff;
  logic                     negate_x;
  logic                     negate_y;
  logic                     rotate_enable;
  logic [CFG_DATA_BITS-1:0] cos_q30;
  logic [CFG_DATA_BITS-1:0] sin_q30;
  logic [CFG_DATA_BITS-1:0] offset_x;
  logic [CFG_DATA_BITS-1:0] offset_y;

  logic [PIPE_LAT-1:0]      vld;

  logic signed [XW-1:0]     sx;
  logic signed [XW-1:0]     sy;
  logic signed [T-1:0]      c_eff;
  logic signed [T-1:0]      s_eff;
  logic signed [XL:0]       xl_s;
  logic signed [XL:0]       yl_s;
  logic signed [XH-1:0]     xh_s;
  logic signed [XH-1:0]     yh_s;

  // stage H partial products
  logic signed [PLW-1:0]    pl_xc, pl_xs, pl_yc, pl_ys;
  logic signed [PHW-1:0]    ph_xc, ph_xs, ph_yc, ph_ys;
  // stage I full products
  logic signed [PFW-1:0]    xc, xs, yc, ys;
  // stage J rotated sums
  logic signed [RW-1:0]     rx, ry;
  // stage K truncated toward zero
  logic signed [TW-1:0]     tx, ty;

  logic signed [SW-1:0]     offx_s, offy_s;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_eff       <= MAG_BITS'(SCALE_DIV);
      negate_x      <= 1'b0;
      negate_y      <= 1'b0;
      rotate_enable <= 1'b0;
      cos_q30       <= CFG_DATA_BITS'(64'd1 << TRIG_FRAC_BITS);
      sin_q30       <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAGNIFICATION: begin
          // unity becomes 1000: multiply by 1000 then divide gives the point exactly
          mag_eff <= (cfg_data[MAG_BITS-1:0] == MAG_BITS'(MAG_UNITY)) ?
                     MAG_BITS'(SCALE_DIV) : cfg_data[MAG_BITS-1:0];
        end
        REG_NEGATE_X:      negate_x      <= cfg_data[0];
        REG_NEGATE_Y:      negate_y      <= cfg_data[0];
        REG_ROTATE_ENABLE: rotate_enable <= cfg_data[0];
        REG_COS:           cos_q30       <= cfg_data;
        REG_SIN:           sin_q30       <= cfg_data;
        REG_OFFSET_X:      offset_x      <= cfg_data;
        REG_OFFSET_Y:      offset_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start};
    end
  end

  assign busy = 1'b0;
  assign done = vld[PIPE_LAT-1];

  // scaling and negation per coordinate
  cipt_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
    .clk     (clk),
    .coord   (point_x),
    .mag_eff (mag_eff),
    .negate  (negate_x),
    .scaled  (sx)
  );

  cipt_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
    .clk     (clk),
    .coord   (point_y),
    .mag_eff (mag_eff),
    .negate  (negate_y),
    .scaled  (sy)
  );

  // rotation off uses cos = 1.0, sin = 0, which passes the point unchanged
  assign c_eff = rotate_enable ? $signed(cos_q30[T-1:0]) : $signed(TRIG_ONE);
  assign s_eff = rotate_enable ? $signed(sin_q30[T-1:0]) : '0;

  // split coordinates into an unsigned low half and a signed high half
  assign xl_s = $signed({1'b0, sx[XL-1:0]});
  assign yl_s = $signed({1'b0, sy[XL-1:0]});
  assign xh_s = $signed(sx[XW-1:XL]);
  assign yh_s = $signed(sy[XW-1:XL]);

  // offsets are signed at coordinate width up to 32 bits, else unsigned 32 bits
  assign offx_s = (COORD_BITS <= 32) ? SW'($signed(offset_x[OFF_W-1:0])) :
                                       SW'({1'b0, offset_x[OFF_W-1:0]});
  assign offy_s = (COORD_BITS <= 32) ? SW'($signed(offset_y[OFF_W-1:0])) :
                                       SW'({1'b0, offset_y[OFF_W-1:0]});

  // rotation and offset datapath
  always_ff @(posedge clk) begin
    // partial products
    pl_xc <= PLW'(xl_s) * PLW'(c_eff);
    pl_xs <= PLW'(xl_s) * PLW'(s_eff);
    pl_yc <= PLW'(yl_s) * PLW'(c_eff);
    pl_ys <= PLW'(yl_s) * PLW'(s_eff);
    ph_xc <= PHW'(xh_s) * PHW'(c_eff);
    ph_xs <= PHW'(xh_s) * PHW'(s_eff);
    ph_yc <= PHW'(yh_s) * PHW'(c_eff);
    ph_ys <= PHW'(yh_s) * PHW'(s_eff);

    // combine halves
    xc <= $signed({ph_xc, {XL{1'b0}}}) + PFW'(pl_xc);
    xs <= $signed({ph_xs, {XL{1'b0}}}) + PFW'(pl_xs);
    yc <= $signed({ph_yc, {XL{1'b0}}}) + PFW'(pl_yc);
    ys <= $signed({ph_ys, {XL{1'b0}}}) + PFW'(pl_ys);

    // rotated sums
    rx <= RW'(xc) - RW'(ys);
    ry <= RW'(xs) + RW'(yc);

    // divide by 2^F, truncating toward zero
    tx <= TW'((rx + (rx[RW-1] ? TBIAS : RW'(0))) >>> TRIG_FRAC_BITS);
    ty <= TW'((ry + (ry[RW-1] ? TBIAS : RW'(0))) >>> TRIG_FRAC_BITS);

    // placement offset, the sum wraps to SW bits, then takes the output width
    placed_x <= OUT_BITS'(SW'(tx) + offx_s);
    placed_y <= OUT_BITS'(SW'(ty) + offy_s);
  end

  // checks
  `CIPT_ASSERT_IMP(a_start_gives_done, start, ##12 done)
  `CIPT_ASSERT_IMP(a_done_had_start, done, $past(start, 12))
  `CIPT_ASSERT_NEVER(a_no_done_after_reset, $fell(rst) && done)

endmodule

`default_nettype wire
